// ===== rtl/bpa_pkg.sv =====
// Shared types and constants of the buddy page allocator.
`default_nettype none
package bpa_pkg;

   localparam int IDX_W    = 15;
   localparam int ORD_IN_W = 4;
   localparam int CNT_W    = 16;
   localparam int CFG_W    = 15;

   typedef enum logic [2:0] {
      CMD_INIT   = 3'd0,
      CMD_ALLOC  = 3'd1,
      CMD_FREE   = 3'd2,
      CMD_ADDREF = 3'd3,
      CMD_GETREF = 3'd4,
      CMD_SPLIT  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OOM     = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/bpa_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/buddy_page_allocator_top.sv =====
// Binary buddy page allocator with per-page reference counts.
// Steps: a rejected request goes from dispatch straight to the response; getref reads the
// count first. Init writes each page and releases it, reading its buddy and merging while
// the buddy is free. Alloc searches up the orders, unlinks the block found, pushes the upper
// half at each split step, then fills its pages. Free/addref/split check every page, then
// write every page back, plus the merges of a last free. One transaction in flight;
// the shared RAM address sets the pace. Synchronous active-high reset; RAMs not cleared.
`default_nettype none
module buddy_page_allocator_top
   import bpa_pkg::*;
#(
   parameter int NUM_PAGES = 32768,
   parameter int MAX_ORDER = 15,
   parameter int REF_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // page_index[14:0], order[18:15], split_order[22:19]
   input  wire logic [2:0]  req_tuser,   // cmd[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // block_index[14:0], ref_count[30:15]
   output logic      [1:0]  rsp_tuser,   // status[1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [14:0] csr_data     // first_usable_page
);

   localparam int AW   = $clog2(NUM_PAGES);
   localparam int XW   = (AW + 2 > 17) ? AW + 2 : 17;
   localparam int OW   = $clog2(MAX_ORDER + 1);
   localparam int NORD = MAX_ORDER + 1;
   localparam int RW   = REF_BITS;
   localparam int LW   = AW + 1;
   localparam int FW   = OW + 1;
   localparam logic [XW-1:0] NPAGES_X = XW'(NUM_PAGES);
   localparam logic [OW-1:0] MAXO     = OW'(MAX_ORDER);
   localparam logic [RW-1:0] REF_MAX  = {RW{1'b1}};

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_INIT_PAGE, S_INIT_NEXT,
      S_REL_CHK, S_REL_RD, S_REL_MERGE,
      S_PUSH_A, S_PUSH_B,
      S_RM_RD, S_RM_P, S_RM_N, S_RM_X,
      S_AL_SEARCH, S_AL_SPLIT, S_AL_FILL,
      S_CK_EV, S_WB, S_GR_EV, S_FINISH
   } state_type;

   state_type state_ff, state_in, op_ret_ff, op_ret_in, rel_ret_ff, rel_ret_in;

   logic              init_ff, init_in;
   logic [CFG_W-1:0]  cfg_ff;
   logic [XW-1:0]     base_ff, base_in, lim_ff, lim_in;
   cmd_type           cmd_ff, cmd_in;
   logic [XW-1:0]     idx_ff, idx_in;
   logic [3:0]        ord_ff, ord_in, nord_ff, nord_in;
   logic [XW-1:0]     wk_idx_ff, wk_idx_in, op_idx_ff, op_idx_in, i_ff, i_in;
   logic [OW-1:0]     wk_ord_ff, wk_ord_in, op_ord_ff, op_ord_in;
   logic [RW-1:0]     ref_ff, ref_in;
   logic [LW-1:0]     nx_ff, nx_in, pv_ff, pv_in;
   logic [AW-1:0]     head_ff [NORD];
   logic [AW-1:0]     head_in [NORD];
   logic [NORD-1:0]   hok_ff, hok_in;
   status_type        res_st_ff, res_st_in;
   logic [IDX_W-1:0]  res_blk_ff, res_blk_in;
   logic [CNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_st_ff, rsp_st_in;
   logic [IDX_W-1:0]  rsp_blk_ff, rsp_blk_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // RAM side
   logic [XW-1:0] pg;
   logic          fo_we, rf_we, nx_we, pv_we;
   logic [FW-1:0] fo_wd, fo_rd;
   logic [RW-1:0] rf_wd, rf_rd;
   logic [LW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

   // Helpers
   logic [XW-1:0] n_x, bud, blk_pg;
   logic [OW-1:0] ord_o, nord_o;
   logic [RW-1:0] r_cur;
   logic          bud_usable, last_pg, ck_bad;

   assign ord_o      = OW'(ord_ff);
   assign nord_o     = OW'(nord_ff);
   assign n_x        = XW'(1) << ord_ff;
   assign bud        = wk_idx_ff ^ (XW'(1) << wk_ord_ff);
   assign bud_usable = (bud >= base_ff) && (bud < lim_ff) && (bud < NPAGES_X);
   assign blk_pg     = idx_ff + i_ff;
   assign last_pg    = (i_ff == n_x - XW'(1));
   assign r_cur      = (i_ff == '0) ? rf_rd : ref_ff;
   assign ck_bad     = fo_rd[FW-1] || (fo_rd[OW-1:0] != ord_o) ||
                       ((i_ff == '0) ? (rf_rd == '0) : (rf_rd != ref_ff));

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cnt_ff, rsp_blk_ff};
   assign rsp_tuser  = rsp_st_ff;

   always_comb begin
      state_in   = state_ff;
      op_ret_in  = op_ret_ff;
      rel_ret_in = rel_ret_ff;
      init_in    = init_ff;
      base_in    = base_ff;
      lim_in     = lim_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      ord_in     = ord_ff;
      nord_in    = nord_ff;
      wk_idx_in  = wk_idx_ff;
      wk_ord_in  = wk_ord_ff;
      op_idx_in  = op_idx_ff;
      op_ord_in  = op_ord_ff;
      i_in       = i_ff;
      ref_in     = ref_ff;
      nx_in      = nx_ff;
      pv_in      = pv_ff;
      head_in    = head_ff;
      hok_in     = hok_ff;
      res_st_in  = res_st_ff;
      res_blk_in = res_blk_ff;
      res_cnt_in = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_st_in  = rsp_st_ff;
      rsp_blk_in = rsp_blk_ff;
      rsp_cnt_in = rsp_cnt_ff;
      pg    = op_idx_ff;
      fo_we = 1'b0;
      rf_we = 1'b0;
      nx_we = 1'b0;
      pv_we = 1'b0;
      fo_wd = '0;
      rf_wd = '0;
      nx_wd = '0;
      pv_wd = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               idx_in   = XW'(req_tdata[14:0]);
               ord_in   = req_tdata[18:15];
               nord_in  = req_tdata[22:19];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_st_in  = ST_INVALID;
            res_blk_in = '0;
            res_cnt_in = '0;
            i_in       = '0;
            state_in   = S_FINISH;
            case (cmd_ff)
               CMD_INIT: begin
                  if (!init_ff) begin
                     init_in = 1'b1;
                     base_in = XW'(cfg_ff);
                     i_in    = XW'(cfg_ff);
                     if (XW'(cfg_ff) >= NPAGES_X) begin
                        lim_in    = NPAGES_X;
                        res_st_in = ST_OK;
                     end else begin
                        state_in = S_INIT_PAGE;
                     end
                  end
               end
               CMD_ALLOC: begin
                  if (int'(ord_ff) <= MAX_ORDER) begin
                     wk_ord_in = ord_o;
                     state_in  = S_AL_SEARCH;
                  end
               end
               CMD_FREE, CMD_ADDREF, CMD_SPLIT: begin
                  // The usable range is contiguous, so range checks cover every page.
                  if (int'(ord_ff) <= MAX_ORDER && idx_ff >= base_ff &&
                      ((idx_ff & (n_x - XW'(1))) == '0) && (idx_ff + n_x <= lim_ff) &&
                      !(cmd_ff == CMD_SPLIT && nord_ff >= ord_ff)) begin
                     pg       = idx_ff;
                     state_in = S_CK_EV;
                  end
               end
               CMD_GETREF: begin
                  if (idx_ff >= base_ff && idx_ff < lim_ff) begin
                     pg       = idx_ff;
                     state_in = S_GR_EV;
                  end
               end
               default: ;
            endcase
         end
         S_INIT_PAGE: begin
            pg         = i_ff;
            fo_we      = 1'b1;
            rf_we      = 1'b1;
            lim_in     = i_ff + XW'(1);
            wk_idx_in  = i_ff;
            wk_ord_in  = '0;
            rel_ret_in = S_INIT_NEXT;
            state_in   = S_REL_CHK;
         end
         S_INIT_NEXT: begin
            if (i_ff + XW'(1) == NPAGES_X) begin
               res_st_in = ST_OK;
               state_in  = S_FINISH;
            end else begin
               i_in     = i_ff + XW'(1);
               state_in = S_INIT_PAGE;
            end
         end
         S_REL_CHK: begin
            op_idx_in = wk_idx_ff;
            op_ord_in = wk_ord_ff;
            op_ret_in = rel_ret_ff;
            if (wk_ord_ff == MAXO || !bud_usable) begin
               state_in = S_PUSH_A;
            end else begin
               pg       = bud;
               state_in = S_REL_RD;
            end
         end
         S_REL_RD: begin
            if (!fo_rd[FW-1] || fo_rd[OW-1:0] != wk_ord_ff) begin
               state_in = S_PUSH_A;
            end else begin
               op_idx_in = bud;
               nx_in     = nx_rd;
               pv_in     = pv_rd;
               op_ret_in = S_REL_MERGE;
               state_in  = S_RM_P;
            end
         end
         S_REL_MERGE: begin
            wk_idx_in = wk_idx_ff & ~(XW'(1) << wk_ord_ff);
            wk_ord_in = wk_ord_ff + OW'(1);
            state_in  = S_REL_CHK;
         end
         S_PUSH_A: begin
            pg    = op_idx_ff;
            fo_we = 1'b1;
            nx_we = 1'b1;
            pv_we = 1'b1;
            fo_wd = {1'b1, op_ord_ff};
            nx_wd = {hok_ff[op_ord_ff], head_ff[op_ord_ff]};
            state_in = S_PUSH_B;
         end
         S_PUSH_B: begin
            // Link the old head back to the new one.
            pg    = XW'(head_ff[op_ord_ff]);
            pv_we = hok_ff[op_ord_ff];
            pv_wd = {1'b1, op_idx_ff[AW-1:0]};
            head_in[op_ord_ff] = op_idx_ff[AW-1:0];
            hok_in[op_ord_ff]  = 1'b1;
            state_in = op_ret_ff;
         end
         S_RM_RD: begin
            nx_in    = nx_rd;
            pv_in    = pv_rd;
            state_in = S_RM_P;
         end
         S_RM_P: begin
            pg    = XW'(pv_ff[AW-1:0]);
            nx_we = pv_ff[AW];
            nx_wd = nx_ff;
            if (!pv_ff[AW]) begin
               head_in[op_ord_ff] = nx_ff[AW-1:0];
               hok_in[op_ord_ff]  = nx_ff[AW];
            end
            state_in = S_RM_N;
         end
         S_RM_N: begin
            pg       = XW'(nx_ff[AW-1:0]);
            pv_we    = nx_ff[AW];
            pv_wd    = pv_ff;
            state_in = S_RM_X;
         end
         S_RM_X: begin
            pg       = op_idx_ff;
            fo_we    = 1'b1;
            fo_wd    = {1'b0, op_ord_ff};
            state_in = op_ret_ff;
         end
         S_AL_SEARCH: begin
            if (hok_ff[wk_ord_ff]) begin
               pg        = XW'(head_ff[wk_ord_ff]);
               wk_idx_in = XW'(head_ff[wk_ord_ff]);
               op_idx_in = XW'(head_ff[wk_ord_ff]);
               op_ord_in = wk_ord_ff;
               op_ret_in = S_AL_SPLIT;
               state_in  = S_RM_RD;
            end else if (wk_ord_ff == MAXO) begin
               res_st_in = ST_OOM;
               state_in  = S_FINISH;
            end else begin
               wk_ord_in = wk_ord_ff + OW'(1);
            end
         end
         S_AL_SPLIT: begin
            if (wk_ord_ff > ord_o) begin
               // Push the upper half one order down.
               wk_ord_in = wk_ord_ff - OW'(1);
               op_ord_in = wk_ord_ff - OW'(1);
               op_idx_in = wk_idx_ff + (XW'(1) << (wk_ord_ff - OW'(1)));
               op_ret_in = S_AL_SPLIT;
               state_in  = S_PUSH_A;
            end else begin
               i_in     = '0;
               state_in = S_AL_FILL;
            end
         end
         S_AL_FILL: begin
            pg    = wk_idx_ff + i_ff;
            fo_we = 1'b1;
            rf_we = 1'b1;
            fo_wd = {1'b0, ord_o};
            rf_wd = RW'(1);
            i_in  = i_ff + XW'(1);
            if (last_pg) begin
               res_st_in  = ST_OK;
               res_blk_in = IDX_W'(wk_idx_ff);
               state_in   = S_FINISH;
            end
         end
         S_CK_EV: begin
            if (ck_bad) begin
               state_in = S_FINISH;
            end else if (last_pg) begin
               ref_in = r_cur;
               i_in   = '0;
               if ((cmd_ff == CMD_ADDREF && r_cur == REF_MAX) ||
                   (cmd_ff == CMD_SPLIT && r_cur != RW'(1))) begin
                  state_in = S_FINISH;
               end else begin
                  res_st_in = ST_OK;
                  if (cmd_ff == CMD_FREE) begin
                     res_cnt_in = CNT_W'(r_cur - RW'(1));
                  end else if (cmd_ff == CMD_ADDREF) begin
                     res_cnt_in = CNT_W'(r_cur + RW'(1));
                  end
                  state_in = S_WB;
               end
            end else begin
               ref_in   = r_cur;
               i_in     = i_ff + XW'(1);
               pg       = blk_pg + XW'(1);
            end
         end
         S_WB: begin
            pg    = blk_pg;
            fo_wd = {1'b0, nord_o};
            fo_we = (cmd_ff == CMD_SPLIT);
            rf_we = (cmd_ff != CMD_SPLIT);
            rf_wd = (cmd_ff == CMD_FREE) ? ref_ff - RW'(1) : ref_ff + RW'(1);
            i_in  = i_ff + XW'(1);
            if (last_pg) begin
               if (cmd_ff == CMD_FREE && ref_ff == RW'(1)) begin
                  wk_idx_in  = idx_ff;
                  wk_ord_in  = ord_o;
                  rel_ret_in = S_FINISH;
                  state_in   = S_REL_CHK;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_GR_EV: begin
            res_st_in  = ST_OK;
            res_cnt_in = CNT_W'(rf_rd);
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_blk_in   = res_blk_ff;
               rsp_cnt_in   = res_cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ret_ff    <= S_IDLE;
         rel_ret_ff   <= S_IDLE;
         init_ff      <= 1'b0;
         cfg_ff       <= '0;
         base_ff      <= '0;
         lim_ff       <= '0;
         hok_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ret_ff    <= op_ret_in;
         rel_ret_ff   <= rel_ret_in;
         init_ff      <= init_in;
         base_ff      <= base_in;
         lim_ff       <= lim_in;
         hok_ff       <= hok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
      end
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      ord_ff     <= ord_in;
      nord_ff    <= nord_in;
      wk_idx_ff  <= wk_idx_in;
      wk_ord_ff  <= wk_ord_in;
      op_idx_ff  <= op_idx_in;
      op_ord_ff  <= op_ord_in;
      i_ff       <= i_in;
      ref_ff     <= ref_in;
      nx_ff      <= nx_in;
      pv_ff      <= pv_in;
      head_ff    <= head_in;
      res_st_ff  <= res_st_in;
      res_blk_ff <= res_blk_in;
      res_cnt_ff <= res_cnt_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_blk_ff <= rsp_blk_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   bpa_ram #(.WIDTH(FW), .DEPTH(NUM_PAGES)) u_fo_ram (
      .clock(clock), .we(fo_we), .addr(pg[AW-1:0]), .wdata(fo_wd), .rdata(fo_rd)
   );
   bpa_ram #(.WIDTH(RW), .DEPTH(NUM_PAGES)) u_ref_ram (
      .clock(clock), .we(rf_we), .addr(pg[AW-1:0]), .wdata(rf_wd), .rdata(rf_rd)
   );
   bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_nxt_ram (
      .clock(clock), .we(nx_we), .addr(pg[AW-1:0]), .wdata(nx_wd), .rdata(nx_rd)
   );
   bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_prv_ram (
      .clock(clock), .we(pv_we), .addr(pg[AW-1:0]), .wdata(pv_wd), .rdata(pv_rd)
   );

endmodule
`default_nettype wire

// ===== rtl/bpa_chk.sv =====
// Port-level checker for the buddy page allocator, bound to the top level.
`default_nettype none
module bpa_chk
   import bpa_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined status code");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == 32'd0)
      else $error("rejected transaction carries data");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind buddy_page_allocator_top bpa_chk u_bpa_chk (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the buddy page allocator: predicts every response and compares.
`timescale 1ns / 100ps
module testbench;
   import bpa_pkg::*;

   localparam int NP        = 32768;
   localparam int TOP_ORD   = 15;
   localparam int CNT_MAX   = 65535;
   localparam int STALL_MAX = 400000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [14:0] page;
      logic [3:0]  ord;
      logic [3:0]  nord;
   } alloc_req_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] blk;
      logic [15:0] cnt;
   } alloc_rsp_t;

   typedef struct packed {
      alloc_req_t req;
      alloc_rsp_t rsp;
   } queued_req_t;

   typedef struct {
      int unsigned page;
      int unsigned ord;
      int unsigned refs;
   } live_block_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [14:0] csr_data = '0;

   buddy_page_allocator_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allocator shadow state
   bit          pg_usable [NP];
   bit          pg_free   [NP];
   bit [3:0]    pg_ord    [NP];
   int unsigned pg_refs   [NP];
   int unsigned nxt       [NP];
   int unsigned prv       [NP];
   bit          nxt_ok    [NP];
   bit          prv_ok    [NP];
   int unsigned head      [TOP_ORD+1];
   bit          head_ok   [TOP_ORD+1];
   bit          pool_ready = 1'b0;
   int unsigned first_page = 0;

   queued_req_t  pending[$];
   alloc_rsp_t   awaited[$];
   live_block_t  live[$];
   int           errors = 0;
   bit           idle_on = 1'b1;
   int unsigned  quiet = 0;

   function automatic void push_free(int unsigned p, int unsigned o);
      pg_ord[p]  = 4'(o);
      pg_free[p] = 1'b1;
      nxt[p]     = head[o];
      nxt_ok[p]  = head_ok[o];
      prv_ok[p]  = 1'b0;
      if (head_ok[o]) begin
         prv[head[o]]    = p;
         prv_ok[head[o]] = 1'b1;
      end
      head[o]    = p;
      head_ok[o] = 1'b1;
   endfunction

   function automatic void unlink(int unsigned p, int unsigned o);
      if (prv_ok[p]) begin
         nxt[prv[p]]    = nxt[p];
         nxt_ok[prv[p]] = nxt_ok[p];
      end else begin
         head[o]    = nxt[p];
         head_ok[o] = nxt_ok[p];
      end
      if (nxt_ok[p]) begin
         prv[nxt[p]]    = prv[p];
         prv_ok[nxt[p]] = prv_ok[p];
      end
      pg_free[p] = 1'b0;
   endfunction

   // return a block to the free lists, merging with free buddies
   function automatic void coalesce(int unsigned p, int unsigned o);
      int unsigned buddy;
      while (o < TOP_ORD) begin
         buddy = p ^ (1 << o);
         if (buddy >= NP) break;
         if (!pg_usable[buddy] || !pg_free[buddy] || pg_ord[buddy] != o) break;
         unlink(buddy, o);
         if (buddy < p) p = buddy;
         o++;
      end
      push_free(p, o);
   endfunction

   function automatic bit owned_block(int unsigned p, int unsigned o, output int unsigned r);
      int unsigned n;
      r = 0;
      if (o > TOP_ORD || p >= NP || !pg_usable[p]) return 1'b0;
      n = 1 << o;
      if ((p & (n - 1)) != 0 || p + n > NP) return 1'b0;
      if (pg_free[p] || pg_ord[p] != o) return 1'b0;
      if (pg_refs[p] < 1) return 1'b0;
      for (int unsigned i = 0; i < n; i++)
         if (!pg_usable[p+i] || pg_free[p+i] || pg_ord[p+i] != o || pg_refs[p+i] != pg_refs[p])
            return 1'b0;
      r = pg_refs[p];
      return 1'b1;
   endfunction

   function automatic alloc_rsp_t allocator_step(alloc_req_t q);
      alloc_rsp_t  a;
      int unsigned o, r, n, blk;
      a.status = ST_INVALID;
      a.blk    = '0;
      a.cnt    = '0;
      case (q.cmd)
         CMD_INIT: if (!pool_ready) begin
            pool_ready = 1'b1;
            for (int unsigned i = first_page; i < NP; i++) begin
               pg_usable[i] = 1'b1;
               pg_refs[i]   = 0;
               pg_ord[i]    = 0;
               pg_free[i]   = 1'b0;
               coalesce(i, 0);
            end
            a.status = ST_OK;
         end
         CMD_ALLOC: begin
            o = q.ord;
            while (o <= TOP_ORD && !head_ok[o]) o++;
            if (o > TOP_ORD) begin
               a.status = ST_OOM;
            end else begin
               blk = head[o];
               unlink(blk, o);
               while (o > q.ord) begin
                  o--;
                  push_free(blk + (1 << o), o);
               end
               for (int unsigned i = 0; i < (1 << q.ord); i++) begin
                  pg_refs[blk+i] = 1;
                  pg_free[blk+i] = 1'b0;
                  pg_ord[blk+i]  = q.ord;
               end
               a.status = ST_OK;
               a.blk    = 15'(blk);
            end
         end
         CMD_FREE: if (owned_block(q.page, q.ord, r)) begin
            n = 1 << q.ord;
            for (int unsigned i = 0; i < n; i++) pg_refs[q.page+i] = r - 1;
            if (r == 1) coalesce(q.page, q.ord);
            a.cnt    = 16'(r - 1);
            a.status = ST_OK;
         end
         CMD_ADDREF: if (owned_block(q.page, q.ord, r) && r < CNT_MAX) begin
            n = 1 << q.ord;
            for (int unsigned i = 0; i < n; i++) pg_refs[q.page+i] = r + 1;
            a.cnt    = 16'(r + 1);
            a.status = ST_OK;
         end
         CMD_GETREF: if (pg_usable[q.page]) begin
            a.cnt    = 16'(pg_refs[q.page]);
            a.status = ST_OK;
         end
         CMD_SPLIT: if (q.nord < q.ord && owned_block(q.page, q.ord, r) && r == 1) begin
            n = 1 << q.ord;
            for (int unsigned i = 0; i < n; i++) pg_ord[q.page+i] = q.nord;
            a.status = ST_OK;
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic int find_live(int unsigned p);
      foreach (live[k]) if (live[k].page == p) return k;
      return -1;
   endfunction

   // predict, queue for the driver and track the blocks held
   task automatic issue(input logic [2:0] cmd, input int unsigned page, input int unsigned ord,
                        input int unsigned nord, output alloc_rsp_t a);
      alloc_req_t  q;
      live_block_t b;
      int          k;
      q.cmd  = cmd;
      q.page = 15'(page);
      q.ord  = 4'(ord);
      q.nord = 4'(nord);
      a = allocator_step(q);
      pending.push_back({q, a});
      if (a.status != ST_OK) return;
      k = find_live(page);
      case (cmd)
         CMD_ALLOC: begin
            b.page = a.blk;
            b.ord  = ord;
            b.refs = 1;
            live.push_back(b);
         end
         CMD_FREE:   if (k >= 0) begin
            if (a.cnt == 0) live.delete(k);
            else live[k].refs = a.cnt;
         end
         CMD_ADDREF: if (k >= 0) live[k].refs = a.cnt;
         CMD_SPLIT:  if (k >= 0) begin
            live.delete(k);
            for (int unsigned i = 0; i < (1 << (ord - nord)); i++) begin
               b.page = page + i * (1 << nord);
               b.ord  = nord;
               b.refs = 1;
               live.push_back(b);
            end
         end
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending.size() != 0 || awaited.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_first_page(input logic [14:0] v);
      drain();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      first_page = v;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   // request driver
   int unsigned req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited.push_back(pending[0].rsp);
            void'(pending.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold the current transaction
         end else if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending[0].req.cmd;
            req_tdata  <= {1'b0, pending[0].req.nord, pending[0].req.ord, pending[0].req.page};
            if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 4);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   int unsigned rsp_gap = 0;
   always @(posedge clock) begin
      alloc_rsp_t w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               report("unexpected response", rsp_tuser, 0);
            end else begin
               w = awaited.pop_front();
               if (rsp_tuser !== w.status) report("status", rsp_tuser, w.status);
               if (rsp_tdata[14:0] !== w.blk) report("block_index", rsp_tdata[14:0], w.blk);
               if (rsp_tdata[30:15] !== w.cnt) report("ref_count", rsp_tdata[30:15], w.cnt);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 4);
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > STALL_MAX) begin
         $display("FAIL buddy_page_allocator_top");
         $finish;
      end
   end

   initial begin
      alloc_rsp_t  a;
      int unsigned pa, pb, pc, o, nd, k, r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // before init nothing is usable
      write_first_page(15'h7FFF);
      issue(CMD_ALLOC, 0, 0, 0, a);
      issue(CMD_FREE, 32767, 0, 0, a);
      issue(CMD_ADDREF, 0, 0, 0, a);
      write_first_page(15'h0000);
      issue(CMD_GETREF, 0, 0, 0, a);
      issue(CMD_SPLIT, 0, 1, 0, a);
      write_first_page(15'($urandom_range(27000, 28672)));
      issue(CMD_INIT, 0, 0, 0, a);

      issue(CMD_GETREF, first_page, 0, 0, a);
      issue(CMD_GETREF, first_page - 1, 0, 0, a);
      issue(CMD_GETREF, 32767, 0, 0, a);
      issue(CMD_ALLOC, 0, TOP_ORD, 0, a);
      issue(CMD_ALLOC, 0, 0, 0, a);  pa = a.blk;
      issue(CMD_ALLOC, 0, 3, 0, a);  pb = a.blk;
      issue(CMD_ALLOC, 0, 12, 0, a); pc = a.blk;
      issue(CMD_ADDREF, pa, 0, 0, a);
      issue(CMD_GETREF, pa, 0, 0, a);
      issue(CMD_FREE, pa, 0, 0, a);
      issue(CMD_FREE, pa, 0, 0, a);
      issue(CMD_FREE, pa, 0, 0, a);
      issue(CMD_FREE, pb, 2, 0, a);
      issue(CMD_FREE, pb + 1, 0, 0, a);
      issue(CMD_SPLIT, pb, 3, 1, a);
      issue(CMD_SPLIT, pb, 3, 0, a);
      issue(CMD_SPLIT, pb + 2, 1, 1, a);
      issue(CMD_ADDREF, pb, 1, 0, a);
      issue(CMD_SPLIT, pb, 1, 0, a);
      issue(3'd6, pb, 1, 0, a);
      issue(3'd7, 15'h7FFF, 15, 15, a);
      issue(CMD_INIT, 0, 0, 0, a);
      issue(CMD_FREE, pc, 12, 0, a);
      drain();

      for (int n = 0; n < 1050; n++) begin
         if (n == 500) begin
            // let every outstanding response return before going on
            write_first_page(15'h0000);
         end
         if (n == 800) write_first_page(15'h7FFF);
         if (n == 900) idle_on = 1'b0;
         r = $urandom_range(0, 99);
         if (live.size() > 60 && r < 30) r = 40;
         if (live.size() == 0 && r < 83) r = 0;
         k = live.size() > 0 ? $urandom_range(0, live.size() - 1) : 0;
         if (r < 30) begin
            o = $urandom_range(0, 99);
            o = o < 70 ? $urandom_range(0, 3) : o < 95 ? $urandom_range(4, 8)
                : $urandom_range(9, TOP_ORD);
            issue(CMD_ALLOC, $urandom_range(0, 32767), o, $urandom_range(0, 15), a);
         end else if (r < 55) begin
            issue(CMD_FREE, live[k].page, live[k].ord, $urandom_range(0, 15), a);
         end else if (r < 65) begin
            issue(CMD_ADDREF, live[k].page, live[k].ord, $urandom_range(0, 15), a);
         end else if (r < 75) begin
            issue(CMD_GETREF, live[k].page + $urandom_range(0, (1 << live[k].ord) - 1), 0, 0, a);
         end else if (r < 83) begin
            o = live[k].ord;
            if (o == 0) nd = 0;
            else nd = $urandom_range(o > 3 ? o - 3 : 0, o - 1);
            issue(CMD_SPLIT, live[k].page, o, nd, a);
         end else if (r < 90 && live.size() > 0) begin
            // broken request on a held block
            issue(3'($urandom_range(CMD_FREE, CMD_SPLIT)), live[k].page + $urandom_range(0, 1),
                  $urandom_range(0, 15), $urandom_range(0, 15), a);
         end else begin
            issue(3'($urandom_range(0, 7)), $urandom_range(0, 32767), $urandom_range(0, 15),
                  $urandom_range(0, 15), a);
         end
         if (pending.size() > 8) while (pending.size() > 2) @(negedge clock);
      end

      drain();
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("PASS buddy_page_allocator_top");
      else
         $display("FAIL buddy_page_allocator_top");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator_top.sv
rtl/bpa_chk.sv
tb/sv/testbench.sv
